// ===== rtl/work_stealing_deque_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef WORK_STEALING_DEQUE_TOP_DEFINES_SVH
`define WORK_STEALING_DEQUE_TOP_DEFINES_SVH

// same-cycle implication
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;
    // DEPTH is a power of two; pointers carry one wrap bit above the slot index
    localparam int unsigned DEPTH      = 64;
    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned ADDR_W     = $clog2(DEPTH);
    localparam int unsigned PTR_W      = ADDR_W + 1;

    typedef logic [1:0]            t_opcode;
    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [PTR_W-1:0]      t_ptr;

    localparam t_opcode OP_PUSH  = 2'd0;
    localparam t_opcode OP_POP   = 2'd1;
    localparam t_opcode OP_STEAL = 2'd2;

    localparam t_ptr DEQUE_CAPACITY = t_ptr'(DEPTH);
endpackage

// ===== rtl/wsd_req_if.sv =====
interface wsd_req_if;
    import wsd_pkg::*;
    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_data   item_in;

    modport source (output valid, output opcode, output item_in, input ready);
    modport sink   (input valid, input opcode, input item_in, output ready);
endinterface

// ===== rtl/wsd_rsp_if.sv =====
interface wsd_rsp_if;
    import wsd_pkg::*;
    logic  valid;
    logic  ready;
    logic  ok;
    t_data item_out;
    t_ptr  occupancy;

    modport source (output valid, output ok, output item_out, output occupancy, input ready);
    modport sink   (input valid, input ok, input item_out, input occupancy, output ready);
endinterface

// ===== rtl/wsd_ram.sv =====
module wsd_ram #(
    parameter int unsigned DEPTH_P = 64,
    parameter int unsigned WIDTH_P = 32,
    localparam int unsigned AW     = $clog2(DEPTH_P)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [WIDTH_P-1:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic [WIDTH_P-1:0] o_rdata
);
    logic [WIDTH_P-1:0] r_mem [DEPTH_P];
    logic [WIDTH_P-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/work_stealing_deque_top.sv =====
// The result is valid in the cycle after the request is accepted (one RAM read).
// Throughput: one request per cycle while the response side is ready; the output
// register takes a new result in the same cycle the previous one is handed off.
// Reset (synchronous, active low): top and bottom pointers to zero, output empty.
// The entry RAM is not cleared; only pushed entries are ever read.
module work_stealing_deque_top (
    input  logic i_clk,
    input  logic i_rst_n,
    wsd_req_if.sink   i_req,
    wsd_rsp_if.source o_rsp
);
    import wsd_pkg::*;

    t_ptr  r_top, r_bot, n_top, n_bot;
    logic  r_valid, r_ok, r_take;
    t_ptr  r_occ;
    t_ptr  cur_occ;
    logic  accept, empty, full, ok, take, we, re;
    t_ptr  bot_dec;
    t_addr raddr;
    t_data rdata;

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign cur_occ = r_bot - r_top;
    assign empty   = (cur_occ == '0);
    assign full    = (cur_occ == DEQUE_CAPACITY);
    assign bot_dec = r_bot - t_ptr'(1);

    always_comb begin
        n_top = r_top;
        n_bot = r_bot;
        ok    = 1'b0;
        take  = 1'b0;
        raddr = r_top[ADDR_W-1:0];
        case (i_req.opcode)
            OP_PUSH: begin
                ok = !full;
                if (!full) begin
                    n_bot = r_bot + t_ptr'(1);
                end
            end
            OP_POP: begin
                ok    = !empty;
                take  = !empty;
                raddr = bot_dec[ADDR_W-1:0];
                if (!empty) begin
                    if (cur_occ == t_ptr'(1)) begin
                        // last item: both pointers meet at the old bottom
                        n_top = r_top + t_ptr'(1);
                        n_bot = r_top + t_ptr'(1);
                    end else begin
                        n_bot = bot_dec;
                    end
                end
            end
            OP_STEAL: begin
                ok   = !empty;
                take = !empty;
                if (!empty) begin
                    n_top = r_top + t_ptr'(1);
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign we = accept && ok && (i_req.opcode == OP_PUSH);
    assign re = accept && take;

    wsd_ram #(
        .DEPTH_P(DEPTH),
        .WIDTH_P(DATA_WIDTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_bot[ADDR_W-1:0]),
        .i_wdata(i_req.item_in),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_bot   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_top   <= n_top;
                r_bot   <= n_bot;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok   <= ok;
            r_take <= take;
            r_occ  <= n_bot - n_top;
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.ok        = r_ok;
    assign o_rsp.item_out  = r_take ? rdata : '0;
    assign o_rsp.occupancy = r_occ;
endmodule

// ===== rtl/wsd_checker.sv =====
`include "work_stealing_deque_top_defines.svh"

module wsd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             o_rsp_valid,
    input logic             o_rsp_ready,
    input logic             o_rsp_ok,
    input wsd_pkg::t_data   o_rsp_item_out,
    input wsd_pkg::t_ptr    o_rsp_occupancy
);
    import wsd_pkg::*;

    // occupancy never exceeds capacity
    `WSD_ASSERT_NOW(a_occ_range, i_clk, i_rst_n, o_rsp_valid, o_rsp_occupancy <= DEQUE_CAPACITY)
    // a failed request returns no item
    `WSD_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_rsp_valid && !o_rsp_ok, o_rsp_item_out == '0)
    // every accepted request shows a result on the next cycle
    `WSD_ASSERT_NEXT(a_result, i_clk, i_rst_n, i_req_valid && i_req_ready, o_rsp_valid)
    // a stalled result holds
    `WSD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_rsp_valid && !o_rsp_ready, o_rsp_valid && $stable(o_rsp_occupancy))
endmodule

bind work_stealing_deque_top wsd_checker u_wsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .o_rsp_valid    (o_rsp.valid),
    .o_rsp_ready    (o_rsp.ready),
    .o_rsp_ok       (o_rsp.ok),
    .o_rsp_item_out (o_rsp.item_out),
    .o_rsp_occupancy(o_rsp.occupancy)
);
